// ----- hw/rtl/ctph_fuzzy_hash_stream_assert.svh -----
// ----------------------------------------------------------------------------
// ctph assertion macros
// shared property forms for the fuzzy hash stream checker
// ----------------------------------------------------------------------------
`ifndef CTPH_FUZZY_HASH_STREAM_ASSERT_SVH
`define CTPH_FUZZY_HASH_STREAM_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CTPH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CTPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ctph_pkg.sv -----
// ----------------------------------------------------------------------------
// ctph_pkg
// types and fixed constants of the context triggered piecewise hash stream
// ----------------------------------------------------------------------------
package ctph_pkg;

    // piece hash arithmetic
    localparam logic [31:0] FNV_MUL    = 32'h0100_0193;
    localparam logic [31:0] PIECE_SEED = 32'h2802_1967;
    localparam logic [31:0] BS_RESET   = 32'd3;

    // rolling hash shift of the third term
    localparam int ROLL_SHIFT = 5;

    // saturation caps of the character counts
    localparam logic [6:0] P1_CNT_CAP = 7'd127;
    localparam logic [5:0] P2_CNT_CAP = 6'd63;

    // result tuser bit positions
    localparam int TUSER_CHAR  = 0;
    localparam int TUSER_PART  = 1;
    localparam int TUSER_SHORT = 2;
    localparam int TUSER_W     = 3;

    // per-byte sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_ROLL,
        ST_SUM,
        ST_DIV,
        ST_CHECK,
        ST_EMIT1,
        ST_EMIT2,
        ST_FIN1,
        ST_FIN2,
        ST_END
    } state_t;

endpackage

// ----- hw/rtl/ctph_fuzzy_hash_stream.sv -----
// ----------------------------------------------------------------------------
// ctph_fuzzy_hash_stream
// context triggered piecewise hash over a byte stream, one byte per beat
// ----------------------------------------------------------------------------
//  channel | dir | tdata              | tuser                             | tlast
//  s_*     | in  | [7:0] data_byte    | [0] new_pass                      | last_byte
//  m_*     | out | [5:0] digest_index | [0] char_valid [1] digest_part    | end_of_digest
//          |     | [7:6] zero         | [2] too_short                     |
//  cfg_*   | in  | cfg_wdata [31:0] trigger size, written when cfg_we is high
//
// a byte goes from accept to the next ready through two passes of the one shared
// 32x32 multiplier, the 32-step serial remainder of the rolling sum by the trigger
// size and the emit steps; a last byte also passes the two final and the end steps.
// each result beat waits in the output register while m_tready is low; the
// sequencer holds in an emit step only when that register is still full.
// rst_n resets all hash state asynchronously and loads the trigger size with 3.
// ----------------------------------------------------------------------------
module ctph_fuzzy_hash_stream #(
    parameter int WINDOW_LEN = 7,
    parameter int SIG_LEN    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // config
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] new_pass
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [5:0] digest_index, [7:6] zero
    output logic [ctph_pkg::TUSER_W-1:0] m_tuser, // [0] char_valid [1] digest_part [2] too_short
    output logic        m_tlast
);

    localparam int POS_W = $clog2(WINDOW_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);
    localparam logic [6:0] P1_LIMIT = 7'(SIG_LEN - 1);
    localparam logic [6:0] P1_SHORT = 7'(SIG_LEN / 2);
    localparam logic [5:0] P2_LIMIT = 6'(SIG_LEN / 2 - 1);

    // control and architectural state
    ctph_pkg::state_t state_reg, state_next;
    logic [31:0] bs_reg, bs_next;
    logic [7:0]  win_reg [WINDOW_LEN];
    logic [7:0]  win_next [WINDOW_LEN];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0] roll_a_reg, roll_a_next;
    logic [31:0] roll_b_reg, roll_b_next;
    logic [31:0] roll_c_reg, roll_c_next;
    logic [31:0] ph1_reg, ph1_next;
    logic [31:0] ph2_reg, ph2_next;
    logic [6:0]  p1_cnt_reg, p1_cnt_next;
    logic [5:0]  p2_cnt_reg, p2_cnt_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;
    logic        m_valid_reg, m_valid_next;

    // working registers
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] div_sh_reg, div_sh_next;
    logic [31:0] rem_reg, rem_next;
    logic        qlsb_reg, qlsb_next;
    logic        trig_reg, trig_next;
    logic        shrt_reg, shrt_next;
    logic [7:0]  m_data_reg, m_data_next;
    logic [ctph_pkg::TUSER_W-1:0] m_user_reg, m_user_next;
    logic        m_last_reg, m_last_next;

    // shared datapath signals
    logic        in_beat;
    logic        out_free;
    logic        want;
    logic        go;
    logic [31:0] mul_a;
    logic [31:0] mul_p;
    logic [31:0] byte_ext;
    logic [32:0] trial;
    logic [32:0] bs_ext;
    logic [31:0] roll_a_upd;
    logic [31:0] roll_b_upd;
    logic [31:0] roll_c_upd;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign byte_ext = {24'd0, byte_reg};

    // ports
    assign s_tready = (state_reg == ctph_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // shared multiplier, first hash then second
    assign mul_a = (state_reg == ctph_pkg::ST_MUL1) ? ph1_reg : ph2_reg;
    assign mul_p = mul_a * ctph_pkg::FNV_MUL;

    // one restoring step of the serial remainder
    assign trial  = {rem_reg, div_sh_reg[31]};
    assign bs_ext = {1'b0, bs_reg};

    // rolling hash terms
    assign roll_b_upd = roll_b_reg - roll_a_reg + (32'(WINDOW_LEN) * byte_ext);
    assign roll_a_upd = roll_a_reg + byte_ext - {24'd0, win_reg[pos_reg]};
    assign roll_c_upd = (roll_c_reg << ctph_pkg::ROLL_SHIFT) ^ byte_ext;

    // whether the current emit step has a beat to send
    always_comb
    begin
        unique case (state_reg)
            ctph_pkg::ST_EMIT1: want = trig_reg && (p1_cnt_reg < P1_LIMIT);
            ctph_pkg::ST_EMIT2: want = trig_reg && qlsb_reg && (p2_cnt_reg < P2_LIMIT);
            ctph_pkg::ST_FIN1,
            ctph_pkg::ST_FIN2:  want = (sum_reg != 32'd0);
            ctph_pkg::ST_END:   want = 1'b1;
            default:            want = 1'b0;
        endcase
        go = !want || out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ctph_pkg::ST_IDLE:  if (in_beat) state_next = ctph_pkg::ST_MUL1;
            ctph_pkg::ST_MUL1:  state_next = ctph_pkg::ST_MUL2;
            ctph_pkg::ST_MUL2:  state_next = ctph_pkg::ST_ROLL;
            ctph_pkg::ST_ROLL:  state_next = ctph_pkg::ST_SUM;
            ctph_pkg::ST_SUM:   state_next = ctph_pkg::ST_DIV;
            ctph_pkg::ST_DIV:   if (div_cnt_reg == 5'd31) state_next = ctph_pkg::ST_CHECK;
            ctph_pkg::ST_CHECK: state_next = ctph_pkg::ST_EMIT1;
            ctph_pkg::ST_EMIT1: if (go) state_next = ctph_pkg::ST_EMIT2;
            ctph_pkg::ST_EMIT2:
            begin
                if (go)
                begin
                    state_next = last_reg ? ctph_pkg::ST_FIN1 : ctph_pkg::ST_IDLE;
                end
            end
            ctph_pkg::ST_FIN1:  if (go) state_next = ctph_pkg::ST_FIN2;
            ctph_pkg::ST_FIN2:  if (go) state_next = ctph_pkg::ST_END;
            ctph_pkg::ST_END:   if (go) state_next = ctph_pkg::ST_IDLE;
            default:            state_next = ctph_pkg::ST_IDLE;
        endcase
    end

    // datapath and result register
    always_comb
    begin
        bs_next      = bs_reg;
        win_next     = win_reg;
        pos_next     = pos_reg;
        roll_a_next  = roll_a_reg;
        roll_b_next  = roll_b_reg;
        roll_c_next  = roll_c_reg;
        ph1_next     = ph1_reg;
        ph2_next     = ph2_reg;
        p1_cnt_next  = p1_cnt_reg;
        p2_cnt_next  = p2_cnt_reg;
        div_cnt_next = div_cnt_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        prod_next    = prod_reg;
        sum_next     = sum_reg;
        div_sh_next  = div_sh_reg;
        rem_next     = rem_reg;
        qlsb_next    = qlsb_reg;
        trig_next    = trig_reg;
        shrt_next    = shrt_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;

        if (cfg_we)
        begin
            bs_next = cfg_wdata;
        end

        unique case (state_reg)
            ctph_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    byte_next = s_tdata;
                    last_next = s_tlast;
                    // new pass restarts pieces, counts and window position
                    if (s_tuser)
                    begin
                        ph1_next    = ctph_pkg::PIECE_SEED;
                        ph2_next    = ctph_pkg::PIECE_SEED;
                        p1_cnt_next = 7'd0;
                        p2_cnt_next = 6'd0;
                        pos_next    = '0;
                    end
                end
            end
            ctph_pkg::ST_MUL1:
            begin
                prod_next = mul_p;
            end
            ctph_pkg::ST_MUL2:
            begin
                ph1_next  = prod_reg ^ byte_ext;
                prod_next = mul_p;
            end
            ctph_pkg::ST_ROLL:
            begin
                ph2_next          = prod_reg ^ byte_ext;
                roll_a_next       = roll_a_upd;
                roll_b_next       = roll_b_upd;
                roll_c_next       = roll_c_upd;
                win_next[pos_reg] = byte_reg;
                pos_next          = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
            end
            ctph_pkg::ST_SUM:
            begin
                sum_next     = roll_a_reg + roll_b_reg + roll_c_reg;
                div_sh_next  = roll_a_reg + roll_b_reg + roll_c_reg;
                rem_next     = 32'd0;
                div_cnt_next = 5'd0;
            end
            ctph_pkg::ST_DIV:
            begin
                // msb first; quotient lsb is the bit of the final step
                div_sh_next  = {div_sh_reg[30:0], 1'b0};
                div_cnt_next = div_cnt_reg + 5'd1;
                if (trial >= bs_ext)
                begin
                    rem_next  = 32'(trial - bs_ext);
                    qlsb_next = 1'b1;
                end
                else
                begin
                    rem_next  = trial[31:0];
                    qlsb_next = 1'b0;
                end
            end
            ctph_pkg::ST_CHECK:
            begin
                trig_next = (bs_reg != 32'd0) && (rem_reg == bs_reg - 32'd1);
            end
            ctph_pkg::ST_EMIT1,
            ctph_pkg::ST_FIN1:
            begin
                if (state_reg == ctph_pkg::ST_FIN1 && go)
                begin
                    shrt_next = (p1_cnt_reg < P1_SHORT);
                end
                if (want && out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, ph1_reg[5:0]};
                    m_user_next  = ctph_pkg::TUSER_W'(1) << ctph_pkg::TUSER_CHAR;
                    m_last_next  = 1'b0;
                    if (p1_cnt_reg != ctph_pkg::P1_CNT_CAP)
                    begin
                        p1_cnt_next = p1_cnt_reg + 7'd1;
                    end
                    if (state_reg == ctph_pkg::ST_EMIT1)
                    begin
                        ph1_next = ctph_pkg::PIECE_SEED;
                    end
                end
            end
            ctph_pkg::ST_EMIT2,
            ctph_pkg::ST_FIN2:
            begin
                if (want && out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, ph2_reg[5:0]};
                    m_user_next  = (ctph_pkg::TUSER_W'(1) << ctph_pkg::TUSER_CHAR)
                                 | (ctph_pkg::TUSER_W'(1) << ctph_pkg::TUSER_PART);
                    m_last_next  = 1'b0;
                    if (p2_cnt_reg != ctph_pkg::P2_CNT_CAP)
                    begin
                        p2_cnt_next = p2_cnt_reg + 6'd1;
                    end
                    if (state_reg == ctph_pkg::ST_EMIT2)
                    begin
                        ph2_next = ctph_pkg::PIECE_SEED;
                    end
                end
            end
            ctph_pkg::ST_END:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = 8'd0;
                    m_user_next  = ctph_pkg::TUSER_W'(shrt_reg) << ctph_pkg::TUSER_SHORT;
                    m_last_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and hash state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ctph_pkg::ST_IDLE;
            bs_reg      <= ctph_pkg::BS_RESET;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_reg[i] <= 8'd0;
            end
            pos_reg     <= '0;
            roll_a_reg  <= 32'd0;
            roll_b_reg  <= 32'd0;
            roll_c_reg  <= 32'd0;
            ph1_reg     <= ctph_pkg::PIECE_SEED;
            ph2_reg     <= ctph_pkg::PIECE_SEED;
            p1_cnt_reg  <= 7'd0;
            p2_cnt_reg  <= 6'd0;
            div_cnt_reg <= 5'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bs_reg      <= bs_next;
            win_reg     <= win_next;
            pos_reg     <= pos_next;
            roll_a_reg  <= roll_a_next;
            roll_b_reg  <= roll_b_next;
            roll_c_reg  <= roll_c_next;
            ph1_reg     <= ph1_next;
            ph2_reg     <= ph2_next;
            p1_cnt_reg  <= p1_cnt_next;
            p2_cnt_reg  <= p2_cnt_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        div_sh_reg <= div_sh_next;
        rem_reg    <= rem_next;
        qlsb_reg   <= qlsb_next;
        trig_reg   <= trig_next;
        shrt_reg   <= shrt_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

endmodule

// ----- hw/rtl/ctph_chk.sv -----
// ----------------------------------------------------------------------------
// ctph_chk
// port level checks of the fuzzy hash stream, bound to the top level
// ----------------------------------------------------------------------------
`include "ctph_fuzzy_hash_stream_assert.svh"

module ctph_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [ctph_pkg::TUSER_W-1:0] m_tuser,
    input logic        m_tlast
);

    // a stalled result beat keeps its payload
    `CTPH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")

    // an accepted byte keeps the block busy for the next cycle
    `CTPH_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input ready right after an accepted beat")

    // the closing beat carries no character
    `CTPH_ASSERT_NOW(a_end_clean, m_tvalid && m_tlast, !m_tuser[ctph_pkg::TUSER_CHAR] && !m_tuser[ctph_pkg::TUSER_PART] && m_tdata == 8'd0, "end beat carries character fields")

    // a character beat is not an end beat
    `CTPH_ASSERT_NOW(a_char_clean, m_tvalid && m_tuser[ctph_pkg::TUSER_CHAR], !m_tlast && !m_tuser[ctph_pkg::TUSER_SHORT] && m_tdata[7:6] == 2'b00, "character beat carries end fields")

    // every result beat is either a character or the end
    `CTPH_ASSERT_NOW(a_beat_kind, m_tvalid && !m_tuser[ctph_pkg::TUSER_CHAR], m_tlast, "result beat is neither character nor end")

endmodule

bind ctph_fuzzy_hash_stream ctph_chk u_ctph_chk (.*);
